[src/double_ended_queue_top_defines.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_top_defines
// assertion macros used by the deque back end
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// property must hold at every rising clock edge outside reset
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define DEQ_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[src/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// types and constants of the bounded double-ended queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned WordW        = 32;
  localparam int unsigned CmdQDepth    = 2;

  localparam logic [WordW-1:0] EmptyAnswer = '1;
  localparam logic [WordW-1:0] TrueWord    = WordW'(1);
  localparam logic [WordW-1:0] FalseWord   = '0;

  typedef enum logic [2:0] {
    OpPushBack  = 3'd0,
    OpPushFront = 3'd1,
    OpPopBack   = 3'd2,
    OpPopFront  = 3'd3,
    OpSize      = 3'd4,
    OpEmpty     = 3'd5,
    OpPeekFront = 3'd6,
    OpPeekBack  = 3'd7
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             is_push;
    logic             at_front;
    logic [WordW-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

[src/deq_front.sv]
// ----------------------------------------------------------------------------
// deq_front
// takes requests, decodes the opcode and queues commands for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output      logic                          busy_o,
  input  wire logic [2:0]                    opcode_i,
  input  wire logic signed [deq_pkg::WordW-1:0] push_value_i,
  output      logic                          cmd_valid_o,
  output      deq_pkg::cmd_t                 cmd_o
);

  localparam int unsigned PtrW = $clog2(deq_pkg::CmdQDepth);
  localparam int unsigned CntW = $clog2(deq_pkg::CmdQDepth + 1);

  deq_pkg::cmd_t       slot_q [deq_pkg::CmdQDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;
  deq_pkg::cmd_t       cmd_new;
  deq_pkg::op_e        op;

  // classify the request
  always_comb begin
    op               = deq_pkg::op_e'(opcode_i);
    cmd_new.op       = op;
    cmd_new.is_push  = (op == deq_pkg::OpPushBack) || (op == deq_pkg::OpPushFront);
    cmd_new.at_front = (op == deq_pkg::OpPushFront) || (op == deq_pkg::OpPopFront) ||
                       (op == deq_pkg::OpPeekFront);
    cmd_new.value    = push_value_i;
  end

  assign busy_o      = (cnt_q == CntW'(deq_pkg::CmdQDepth));
  assign push        = start_i && !busy_o;
  assign pop         = (cnt_q != '0);
  assign cmd_valid_o = pop;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(deq_pkg::CmdQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(deq_pkg::CmdQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

[src/deq_back.sv]
// ----------------------------------------------------------------------------
// deq_back
// executes queued commands on the ring store and drives the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_top_defines.svh"

module deq_back #(
  parameter int unsigned DEPTH = deq_pkg::DepthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire deq_pkg::cmd_t                 cmd_i,
  output      logic                          valid_o,
  output      logic signed [deq_pkg::WordW-1:0] result_value_o,
  output      logic                          push_dropped_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  logic [deq_pkg::WordW-1:0] mem [DEPTH];
  logic [deq_pkg::WordW-1:0] rd_data_q;

  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;

  logic                      out_valid_q, out_valid_d;
  logic                      out_mem_q, out_mem_d;
  logic                      out_drop_q, out_drop_d;
  logic [deq_pkg::WordW-1:0] out_value_q, out_value_d;

  logic                      wr_en, rd_en;
  logic [IdxW-1:0]           wr_addr, rd_addr;

  logic            full, empty;
  logic [SumW-1:0] sum, sum_m1;
  logic [IdxW-1:0] tail_pos, back_pos, front_inc, front_dec;

  always_comb begin
    full      = (count_q == CntW'(DEPTH));
    empty     = (count_q == '0);
    sum       = SumW'(front_q) + SumW'(count_q);
    sum_m1    = sum - 1'b1;
    tail_pos  = (sum >= SumW'(DEPTH)) ? IdxW'(sum - SumW'(DEPTH)) : IdxW'(sum);
    back_pos  = (sum_m1 >= SumW'(DEPTH)) ? IdxW'(sum_m1 - SumW'(DEPTH)) : IdxW'(sum_m1);
    front_inc = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
    front_dec = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - 1'b1;
  end

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    out_valid_d = 1'b0;
    out_mem_d   = 1'b0;
    out_drop_d  = 1'b0;
    out_value_d = deq_pkg::FalseWord;
    wr_en       = 1'b0;
    wr_addr     = tail_pos;
    rd_en       = 1'b0;
    rd_addr     = front_q;
    if (cmd_valid_i) begin
      unique case (cmd_i.op)
        deq_pkg::OpPushBack, deq_pkg::OpPushFront: begin
          if (full) begin
            out_valid_d = 1'b1;
            out_drop_d  = 1'b1;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
            if (cmd_i.at_front) begin
              wr_addr = front_dec;
              front_d = front_dec;
            end
          end
        end
        deq_pkg::OpPopBack, deq_pkg::OpPopFront,
        deq_pkg::OpPeekFront, deq_pkg::OpPeekBack: begin
          out_valid_d = 1'b1;
          if (empty) begin
            out_value_d = deq_pkg::EmptyAnswer;
          end else begin
            out_mem_d = 1'b1;
            rd_en     = 1'b1;
            rd_addr   = cmd_i.at_front ? front_q : back_pos;
            if (cmd_i.op == deq_pkg::OpPopBack) begin
              count_d = count_q - 1'b1;
            end else if (cmd_i.op == deq_pkg::OpPopFront) begin
              count_d = count_q - 1'b1;
              front_d = front_inc;
            end
          end
        end
        deq_pkg::OpSize: begin
          out_valid_d = 1'b1;
          out_value_d = deq_pkg::WordW'(count_q);
        end
        deq_pkg::OpEmpty: begin
          out_valid_d = 1'b1;
          out_value_d = empty ? deq_pkg::TrueWord : deq_pkg::FalseWord;
        end
        default: begin
          out_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_mem_q   <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_mem_q   <= out_mem_d;
      out_drop_q  <= out_drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

  assign valid_o        = out_valid_q;
  assign push_dropped_o = out_drop_q;
  assign result_value_o = out_mem_q ? rd_data_q : out_value_q;

  `DEQ_ASSERT_NEVER(a_count_bound, count_q > CntW'(DEPTH), "entry count above depth")
  `DEQ_ASSERT_NEVER(a_front_bound, SumW'(front_q) >= SumW'(DEPTH), "front index out of range")
  `DEQ_ASSERT(a_strobe_cause, valid_o |-> $past(cmd_valid_i), "result without a command")
  `DEQ_ASSERT(a_push_grows, (cmd_valid_i && cmd_i.is_push && !full) |=> (count_q == CntW'($past(count_q) + 1'b1)), "push did not add an entry")
  `DEQ_ASSERT(a_drop_only_full, (out_drop_d && cmd_valid_i) |-> full, "push dropped with room left")

endmodule

`default_nettype wire

[src/double_ended_queue_top.sv]
// a taken request is held in the command queue, then its result is registered in the back end
// (in the ring store read register, or in the output value register)
// throughput: one request per cycle; busy_o stays low, the back end drains a command each cycle
// the receiver cannot stall: each result is on the ports for one cycle only
// reset: asynchronous, active low; clears the queue, front index and count
// ----------------------------------------------------------------------------
// double_ended_queue_top
// bounded double-ended queue of signed words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_top #(
  parameter int unsigned DEPTH = deq_pkg::DepthDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output      logic                             busy_o,
  input  wire logic [2:0]                       opcode_i,
  input  wire logic signed [deq_pkg::WordW-1:0] push_value_i,
  output      logic                             valid_o,
  output      logic signed [deq_pkg::WordW-1:0] result_value_o,
  output      logic                             push_dropped_o
);

  logic          cmd_valid;
  deq_pkg::cmd_t cmd;

  deq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .push_value_i (push_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .valid_o        (valid_o),
    .result_value_o (result_value_o),
    .push_dropped_o (push_dropped_o)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the bounded double-ended queue against a behavioral copy of the ring;
// a directed table covers the state after reset, empty and full cases, then random requests
// wander the fill level between empty and full under varied sender gaps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned Depth = deq_pkg::DepthDefault;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned FillW = IdxW + 1;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems = 450;

  typedef struct packed {
    logic [deq_pkg::WordW-1:0] value;
    logic                      dropped;
  } answer_t;

  typedef struct {
    deq_pkg::op_e              op;
    logic [deq_pkg::WordW-1:0] word;
    int                        reps;
    logic                      known;
    logic [deq_pkg::WordW-1:0] value;
    logic                      dropped;
  } plan_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             start_i = 1'b0;
  logic [2:0]                       opcode_i = '0;
  logic signed [deq_pkg::WordW-1:0] push_value_i = '0;
  logic                             busy_o;
  logic                             valid_o;
  logic signed [deq_pkg::WordW-1:0] result_value_o;
  logic                             push_dropped_o;

  double_ended_queue_top #(.DEPTH(Depth)) dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .opcode_i,
    .push_value_i,
    .valid_o,
    .result_value_o,
    .push_dropped_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the ring
  logic [deq_pkg::WordW-1:0] ring [Depth];
  logic [IdxW-1:0]  head = '0;
  logic [FillW-1:0] fill = '0;

  answer_t answers_due [$];
  int      failures = 0;
  logic    fixed_known = 1'b0;
  answer_t fixed_answer = '0;
  logic    filling = 1'b1;

  task automatic predict_answer(input deq_pkg::op_e op, input logic [deq_pkg::WordW-1:0] word,
                                output logic has_answer, output answer_t ans);
    logic [IdxW-1:0] tail;
    tail = head + fill[IdxW-1:0] - IdxW'(1);
    has_answer = 1'b1;
    ans.value = deq_pkg::FalseWord;
    ans.dropped = 1'b0;
    case (op)
      deq_pkg::OpPushBack, deq_pkg::OpPushFront: begin
        if (fill == FillW'(Depth)) begin
          ans.dropped = 1'b1;
        end else begin
          has_answer = 1'b0;
          if (op == deq_pkg::OpPushFront) begin
            head = head - IdxW'(1);
            ring[head] = word;
          end else begin
            ring[head + fill[IdxW-1:0]] = word;
          end
          fill = fill + FillW'(1);
        end
      end
      deq_pkg::OpPopBack, deq_pkg::OpPopFront, deq_pkg::OpPeekFront,
      deq_pkg::OpPeekBack: begin
        if (fill == '0) begin
          ans.value = deq_pkg::EmptyAnswer;
        end else if (op == deq_pkg::OpPopBack || op == deq_pkg::OpPeekBack) begin
          ans.value = ring[tail];
          if (op == deq_pkg::OpPopBack) fill = fill - FillW'(1);
        end else begin
          ans.value = ring[head];
          if (op == deq_pkg::OpPopFront) begin
            head = head + IdxW'(1);
            fill = fill - FillW'(1);
          end
        end
      end
      deq_pkg::OpSize: ans.value = deq_pkg::WordW'(fill);
      default: ans.value = (fill == '0) ? deq_pkg::TrueWord : deq_pkg::FalseWord;
    endcase
  endtask

  // results are checked and new requests predicted mid-cycle, on the falling edge away from the rising edges
  always @(negedge clk_i) begin
    logic    has_answer;
    answer_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (answers_due.size() == 0) begin
          $error("result with nothing expected: value %0d dropped %0b",
                 result_value_o, push_dropped_o);
          failures++;
        end else begin
          want = answers_due[0];
          answers_due.delete(0);
          if (result_value_o !== want.value) begin
            $error("result_value: expected %0d, got %0d", $signed(want.value),
                   result_value_o);
            failures++;
          end
          if (push_dropped_o !== want.dropped) begin
            $error("push_dropped: expected %0b, got %0b", want.dropped, push_dropped_o);
            failures++;
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_answer(deq_pkg::op_e'(opcode_i), push_value_i, has_answer, want);
        if (has_answer) begin
          answers_due.insert(answers_due.size(), fixed_known ? fixed_answer : want);
        end
      end
    end
  end

  task automatic issue(input deq_pkg::op_e op, input logic [deq_pkg::WordW-1:0] word);
    start_i <= 1'b1;
    opcode_i <= op;
    push_value_i <= word;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  task automatic pause(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // hold off until every expected result is back and the pipe is empty
  task automatic settle();
    start_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [deq_pkg::WordW-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(deq_pkg::WordW-1){1'b0}}};
      3: return {1'b0, {(deq_pkg::WordW-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  // drift the fill level toward full, then toward empty, and back, with size, empty and peek queries mixed in
  function automatic deq_pkg::op_e pick_op();
    int roll;
    if (fill == FillW'(Depth)) filling = 1'b0;
    else if (fill == '0) filling = 1'b1;
    else if ($urandom_range(99) < 3) filling = !filling;
    roll = $urandom_range(99);
    if ((roll < 55) == filling && roll < 75) begin
      return $urandom_range(1) ? deq_pkg::OpPushFront : deq_pkg::OpPushBack;
    end else if (roll < 75) begin
      return $urandom_range(1) ? deq_pkg::OpPopFront : deq_pkg::OpPopBack;
    end
    case ($urandom_range(3))
      0: return deq_pkg::OpSize;
      1: return deq_pkg::OpEmpty;
      2: return deq_pkg::OpPeekFront;
      default: return deq_pkg::OpPeekBack;
    endcase
  endfunction

  task automatic random_phase(input int idle_pct);
    repeat (PhaseItems) begin
      if ($urandom_range(99) < idle_pct) pause($urandom_range(1, 4));
      issue(pick_op(), pick_word());
    end
  endtask

  localparam logic [deq_pkg::WordW-1:0] MaxWord = {1'b0, {(deq_pkg::WordW-1){1'b1}}};
  localparam logic [deq_pkg::WordW-1:0] MinWord = {1'b1, {(deq_pkg::WordW-1){1'b0}}};
  localparam logic [deq_pkg::WordW-1:0] FillWord = 32'h5a5a_a5a5;
  localparam logic [deq_pkg::WordW-1:0] TrueW  = deq_pkg::TrueWord;
  localparam logic [deq_pkg::WordW-1:0] FalseW = deq_pkg::FalseWord;
  localparam logic [deq_pkg::WordW-1:0] EmptyW = deq_pkg::EmptyAnswer;

  plan_row_t plan [24];

  initial begin
    for (int i = 0; i < Depth; i++) ring[i] = '0;
    plan = '{
      '{deq_pkg::OpEmpty,     '0,       1,  1'b1, TrueW,                 1'b0},
      '{deq_pkg::OpSize,      '1,       1,  1'b1, FalseW,                1'b0},
      '{deq_pkg::OpPopBack,   '0,       1,  1'b1, EmptyW,                1'b0},
      '{deq_pkg::OpPopFront,  '0,       1,  1'b1, EmptyW,                1'b0},
      '{deq_pkg::OpPeekFront, '0,       1,  1'b1, EmptyW,                1'b0},
      '{deq_pkg::OpPeekBack,  '0,       1,  1'b1, EmptyW,                1'b0},
      '{deq_pkg::OpPushBack,  MaxWord,  1,  1'b0, '0,                    1'b0},
      '{deq_pkg::OpPushFront, MinWord,  1,  1'b0, '0,                    1'b0},
      '{deq_pkg::OpPushBack,  '1,       1,  1'b0, '0,                    1'b0},
      '{deq_pkg::OpPushFront, '0,       1,  1'b0, '0,                    1'b0},
      '{deq_pkg::OpSize,      '0,       1,  1'b1, deq_pkg::WordW'(4),    1'b0},
      '{deq_pkg::OpEmpty,     '0,       1,  1'b1, FalseW,                1'b0},
      '{deq_pkg::OpPeekFront, '0,       1,  1'b1, '0,                    1'b0},
      '{deq_pkg::OpPeekBack,  '0,       1,  1'b1, '1,                    1'b0},
      '{deq_pkg::OpPopFront,  '0,       1,  1'b1, '0,                    1'b0},
      '{deq_pkg::OpPopBack,   '0,       1,  1'b1, '1,                    1'b0},
      '{deq_pkg::OpPushBack,  FillWord, 14, 1'b0, '0,                    1'b0},
      '{deq_pkg::OpPushBack,  MaxWord,  1,  1'b1, '0,                    1'b1},
      '{deq_pkg::OpPushFront, MinWord,  1,  1'b1, '0,                    1'b1},
      '{deq_pkg::OpSize,      '0,       1,  1'b1, deq_pkg::WordW'(16),   1'b0},
      '{deq_pkg::OpPeekFront, '0,       1,  1'b1, MinWord,               1'b0},
      '{deq_pkg::OpPeekBack,  '0,       1,  1'b1, FillWord,              1'b0},
      '{deq_pkg::OpPopFront,  '0,       16, 1'b0, '0,                    1'b0},
      '{deq_pkg::OpEmpty,     '0,       1,  1'b1, TrueW,                 1'b0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      repeat (plan[r].reps) begin
        fixed_known = plan[r].known;
        fixed_answer = '{value: plan[r].value, dropped: plan[r].dropped};
        issue(plan[r].op, plan[r].word);
      end
    end
    fixed_known = 1'b0;
    settle();

    random_phase(15);
    settle();
    random_phase(60);
    settle();
    random_phase(0);
    settle();

    if (failures == 0) begin
      $display("double_ended_queue_top test passed");
    end else begin
      $display("double_ended_queue_top test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("double_ended_queue_top test failed");
    $finish;
  end

endmodule
